[design/kce_pkg.sv]
`timescale 1ns / 1ps

package kce_pkg;

    localparam int ITEM_W        = 8;
    localparam int SLOT_W        = 6;
    localparam int CMD_W         = 2;
    localparam int SET_SIZE_W    = 7;
    localparam int SUBSET_SIZE_W = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 7;
    localparam int PICK_OUTPUTS  = 8;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EMIT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSET_SIZE = 1'd1;

    localparam logic [SET_SIZE_W-1:0]    SET_SIZE_RESET    = 7'd40;
    localparam logic [SUBSET_SIZE_W-1:0] SUBSET_SIZE_RESET = 4'd5;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] item_slot;
        logic [ITEM_W-1:0] item_value;
    } cmd_t;

    typedef struct packed {
        logic [ITEM_W-1:0] pick_0;
        logic [ITEM_W-1:0] pick_1;
        logic [ITEM_W-1:0] pick_2;
        logic [ITEM_W-1:0] pick_3;
        logic [ITEM_W-1:0] pick_4;
        logic [ITEM_W-1:0] pick_5;
        logic [ITEM_W-1:0] pick_6;
        logic [ITEM_W-1:0] pick_7;
        logic              final_subset;
        logic              bad_setting;
    } rsp_t;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic restart;
        logic advance;
        logic capture;
        logic shift_addr;
        logic shift_pick;
    } cell_ctl_t;

endpackage

[design/kce_stream_if.sv]
`timescale 1ns / 1ps

interface kce_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[design/kce_store.sv]
`timescale 1ns / 1ps

module kce_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [kce_pkg::ITEM_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [kce_pkg::ITEM_W-1:0] rdata
);
    import kce_pkg::*;

    logic [ITEM_W-1:0] mem [DEPTH];
    logic [ITEM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((AW + 1)'(raddr) < (AW + 1)'(DEPTH))
        begin
            rdata_reg <= mem[raddr];
        end
        else
        begin
            rdata_reg <= '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/kce_cell.sv]
`timescale 1ns / 1ps

module kce_cell #(
    parameter int IW  = 6,
    parameter int CW  = 8,
    parameter int POS = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kce_pkg::cell_ctl_t                ctl,
    input  logic [kce_pkg::SET_SIZE_W-1:0]    n,
    input  logic [kce_pkg::SUBSET_SIZE_W-1:0] k,
    input  logic [IW-1:0]                     left_idx,
    input  logic                              left_rose,
    input  logic                              right_found,
    input  logic [IW-1:0]                     addr_in,
    input  logic                              live_in,
    input  logic [kce_pkg::ITEM_W-1:0]        pick_in,
    output logic [IW-1:0]                     next_idx,
    output logic                              rose,
    output logic                              found,
    output logic [IW-1:0]                     addr,
    output logic                              live,
    output logic [kce_pkg::ITEM_W-1:0]        pick
);
    import kce_pkg::*;

    logic [IW-1:0]     idx_reg;
    logic [IW-1:0]     idx_next;
    logic [IW-1:0]     addr_reg;
    logic              live_reg;
    logic [ITEM_W-1:0] pick_reg;
    logic              active;
    logic [CW-1:0]     ceiling;
    logic              can_rise;
    logic              rise_here;

    // This position takes part in the subset when POS < k, and its ceiling is n - k + POS.
    assign active    = CW'(POS) < CW'(k);
    assign ceiling   = CW'(n) + CW'(POS) - CW'(k);
    assign can_rise  = active && (CW'(idx_reg) < ceiling);

    // The rightmost position that can rise is the one with no riser to its right.
    assign rise_here = can_rise && !right_found;
    assign found     = right_found || can_rise;
    assign rose      = left_rose || rise_here;

    always_comb
    begin
        priority if (rise_here)
        begin
            next_idx = idx_reg + 1'b1;
        end
        else if (left_rose && active)
        begin
            next_idx = left_idx + 1'b1;
        end
        else
        begin
            next_idx = idx_reg;
        end
    end

    always_comb
    begin
        priority if (ctl.restart)
        begin
            idx_next = IW'(POS);
        end
        else if (ctl.advance)
        begin
            idx_next = next_idx;
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= IW'(POS);
            live_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (ctl.capture)
            begin
                live_reg <= active;
            end
            else if (ctl.shift_addr)
            begin
                live_reg <= live_in;
            end
        end
    end

    // The address line moves toward position zero, which drives the store.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            addr_reg <= idx_reg;
        end
        else if (ctl.shift_addr)
        begin
            addr_reg <= addr_in;
        end
        if (ctl.shift_pick)
        begin
            pick_reg <= pick_in;
        end
    end

    assign addr = addr_reg;
    assign live = live_reg;
    assign pick = pick_reg;

endmodule

[design/k_combination_enumerator.sv]
`timescale 1ns / 1ps

// Lexicographic k-combination generator over a loaded item store.
// Commands arrive as transactions on cmd_chan: load writes item_value into
// item_slot, restart puts the indices back to 0..k-1, and emit returns one
// transaction on subset_chan with the items at the current k indices, then
// advances to the next subset (wrapping after the final one).
// Set size n and subset size k are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block does
// not enforce. Either write restarts the enumeration. Load and restart are
// accepted back to back. An emit holds the block busy while the indices sit
// in a chain of cells whose address line shifts one position a cycle into the
// single read port of the store; the picks enter at the last cell and shift
// along the same chain toward position zero. With unusable settings the store
// is not read and the result is flagged by bad_setting.
// A pending result is held in an output register; loads and restarts are still
// accepted while the receiver stalls, but the next emit completes only once
// that register is free.
// Reset sets n = 40, k = 5 and indices 0..k-1; the store is not cleared and
// must be loaded before its entries are used.
module k_combination_enumerator #(
    parameter int MAX_SET    = 64,
    parameter int MAX_SUBSET = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    kce_stream_if.sink                     cmd_chan,
    kce_stream_if.source                   subset_chan,
    input  logic                           cfg_we,
    input  logic [kce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kce_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kce_pkg::*;

    localparam int IW    = (MAX_SET > 2) ? $clog2(MAX_SET) : 1;
    localparam int CW    = ((IW > SET_SIZE_W) ? IW : SET_SIZE_W) + 1;
    localparam int CNT_W = $clog2(MAX_SUBSET + 1);
    localparam int SW    = 10;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [SET_SIZE_W-1:0]    set_size_reg;
    logic [SUBSET_SIZE_W-1:0] subset_size_reg;
    logic                     final_reg, final_next;
    logic                     bad_reg, bad_next;
    logic                     out_valid_reg, out_valid_next;
    rsp_t                     out_reg;
    logic                     live_d_reg;

    cmd_t        cmd;
    logic        cmd_acc;
    logic        is_load, is_emit, is_restart;
    logic        settings_bad;
    logic        cfg_hit;
    logic        store_we;
    logic        load_out;
    cell_ctl_t   ctl;
    logic [ITEM_W-1:0] rdata;

    logic [IW-1:0]     next_idx_w [MAX_SUBSET];
    logic              rose_w     [MAX_SUBSET];
    logic              found_w    [MAX_SUBSET];
    logic [IW-1:0]     addr_w     [MAX_SUBSET];
    logic              live_w     [MAX_SUBSET];
    logic [ITEM_W-1:0] pick_w     [MAX_SUBSET];
    logic [ITEM_W-1:0] pick_bus   [PICK_OUTPUTS];

    assign cmd            = cmd_chan.payload;
    assign cmd_chan.ready = (state_reg == ST_IDLE);
    assign cmd_acc        = cmd_chan.valid && cmd_chan.ready;
    assign is_load        = cmd_acc && (cmd.command == CMD_LOAD);
    assign is_emit        = cmd_acc && (cmd.command == CMD_EMIT);
    assign is_restart     = cmd_acc && (cmd.command == CMD_RESTART);

    assign settings_bad = (subset_size_reg == '0)
                       || (SW'(subset_size_reg) > SW'(MAX_SUBSET))
                       || (SW'(set_size_reg) > SW'(MAX_SET))
                       || (SW'(subset_size_reg) > SW'(set_size_reg));

    assign store_we = is_load && (SW'(cmd.item_slot) < SW'(MAX_SET));

    always_comb
    begin
        cfg_hit = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SET_SIZE:    cfg_hit = 1'b1;
                REG_SUBSET_SIZE: cfg_hit = 1'b1;
                default:         cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg    <= SET_SIZE_RESET;
            subset_size_reg <= SUBSET_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SET_SIZE:    set_size_reg    <= cfg_data[SET_SIZE_W-1:0];
                REG_SUBSET_SIZE: subset_size_reg <= cfg_data[SUBSET_SIZE_W-1:0];
                default:         set_size_reg    <= set_size_reg;
            endcase
        end
    end

    // When no cell can rise, this is the final subset and the indices wrap.
    always_comb
    begin
        ctl.capture    = is_emit && !settings_bad;
        ctl.advance    = is_emit && !settings_bad && found_w[0];
        ctl.restart    = cfg_hit || is_restart
                      || (is_emit && !settings_bad && !found_w[0]);
        ctl.shift_addr = (state_reg == ST_READ) && (cnt_reg < CNT_W'(MAX_SUBSET));
        ctl.shift_pick = (state_reg == ST_READ) && (cnt_reg != '0);
    end

    kce_store #(
        .DEPTH (MAX_SET),
        .AW    (IW)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (IW'(cmd.item_slot)),
        .wdata (cmd.item_value),
        .raddr (addr_w[0]),
        .rdata (rdata)
    );

    genvar g;
    generate
        for (g = 0; g < MAX_SUBSET; g++)
        begin : g_cell
            logic [IW-1:0]     left_idx;
            logic              left_rose;
            logic              right_found;
            logic [IW-1:0]     addr_in;
            logic              live_in;
            logic [ITEM_W-1:0] pick_in;

            if (g == 0)
            begin : g_first
                assign left_idx  = '0;
                assign left_rose = 1'b0;
            end
            else
            begin : g_inner_left
                assign left_idx  = next_idx_w[g-1];
                assign left_rose = rose_w[g-1];
            end

            if (g == MAX_SUBSET - 1)
            begin : g_last
                assign right_found = 1'b0;
                assign addr_in     = '0;
                assign live_in     = 1'b0;
                assign pick_in     = live_d_reg ? rdata : '0;
            end
            else
            begin : g_inner_right
                assign right_found = found_w[g+1];
                assign addr_in     = addr_w[g+1];
                assign live_in     = live_w[g+1];
                assign pick_in     = pick_w[g+1];
            end

            kce_cell #(
                .IW  (IW),
                .CW  (CW),
                .POS (g)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .n           (set_size_reg),
                .k           (subset_size_reg),
                .left_idx    (left_idx),
                .left_rose   (left_rose),
                .right_found (right_found),
                .addr_in     (addr_in),
                .live_in     (live_in),
                .pick_in     (pick_in),
                .next_idx    (next_idx_w[g]),
                .rose        (rose_w[g]),
                .found       (found_w[g]),
                .addr        (addr_w[g]),
                .live        (live_w[g]),
                .pick        (pick_w[g])
            );
        end

        for (g = 0; g < PICK_OUTPUTS; g++)
        begin : g_pick
            if (g < MAX_SUBSET)
            begin : g_used
                assign pick_bus[g] = bad_reg ? '0 : pick_w[g];
            end
            else
            begin : g_unused
                assign pick_bus[g] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_d_reg <= 1'b0;
        end
        else
        begin
            live_d_reg <= live_w[0];
        end
    end

    assign load_out = (state_reg == ST_WAIT) && (!out_valid_reg || subset_chan.ready);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        final_next     = final_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg;
        if (subset_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_emit)
                begin
                    cnt_next = '0;
                    if (settings_bad)
                    begin
                        bad_next   = 1'b1;
                        final_next = 1'b0;
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        bad_next   = 1'b0;
                        final_next = !found_w[0];
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (cnt_reg == CNT_W'(MAX_SUBSET))
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            final_reg     <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            final_reg     <= final_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.pick_0       <= pick_bus[0];
            out_reg.pick_1       <= pick_bus[1];
            out_reg.pick_2       <= pick_bus[2];
            out_reg.pick_3       <= pick_bus[3];
            out_reg.pick_4       <= pick_bus[4];
            out_reg.pick_5       <= pick_bus[5];
            out_reg.pick_6       <= pick_bus[6];
            out_reg.pick_7       <= pick_bus[7];
            out_reg.final_subset <= final_reg;
            out_reg.bad_setting  <= bad_reg;
        end
    end

    assign subset_chan.valid   = out_valid_reg;
    assign subset_chan.payload = out_reg;

    a_bad_zero : assert property (@(posedge clk) disable iff (!rst_n)
        subset_chan.valid && subset_chan.payload.bad_setting |->
            subset_chan.payload.pick_0 == '0 && subset_chan.payload.pick_1 == '0 &&
            subset_chan.payload.pick_2 == '0 && subset_chan.payload.pick_3 == '0 &&
            subset_chan.payload.pick_4 == '0 && subset_chan.payload.pick_5 == '0 &&
            subset_chan.payload.pick_6 == '0 && subset_chan.payload.pick_7 == '0 &&
            !subset_chan.payload.final_subset)
        else $error("bad setting result carries data");

    a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_SUBSET))
        else $error("read counter out of range");

    a_emit_reads : assert property (@(posedge clk) disable iff (!rst_n)
        is_emit && !settings_bad |=> state_reg == ST_READ && cnt_reg == '0)
        else $error("emit did not start the store read");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WAIT && subset_chan.valid && !subset_chan.ready |=>
            state_reg == ST_WAIT && $stable(subset_chan.payload))
        else $error("pending result overwritten");

endmodule

[verif/k_combination_enumerator_test.sv]
`timescale 1ns / 1ps

module k_combination_enumerator_test;

    import kce_pkg::*;

    localparam int MAX_SET       = 64;
    localparam int MAX_SUBSET    = 8;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int SETTLE_CYCLES = MAX_SUBSET + 8;
    localparam int PLAN_ROWS     = 26;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        cmd_t                     item;
        logic [CFG_IDX_W-1:0]     reg_index;
        logic [CFG_DATA_W-1:0]    reg_data;
        bit                       typed;
        rsp_t                     subset;
    } plan_row_t;

    // The store is filled with slot * 4 + 3 before the table runs.
    localparam rsp_t RSP_AFTER_RESET =
        '{8'h03, 8'h07, 8'h0B, 8'h0F, 8'h13, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0};
    localparam rsp_t RSP_SINGLE_FINAL =
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0};
    localparam rsp_t RSP_REJECTED =
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1};
    localparam rsp_t RSP_NONE = '0;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kce_stream_if #(.payload_t(cmd_t)) cmd_chan ();
    kce_stream_if #(.payload_t(rsp_t)) subset_chan ();

    k_combination_enumerator #(
        .MAX_SET    (MAX_SET),
        .MAX_SUBSET (MAX_SUBSET)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_chan    (cmd_chan),
        .subset_chan (subset_chan),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Mirror of the block state used for prediction.
    logic [ITEM_W-1:0]        item_mirror [MAX_SET];
    logic [SLOT_W-1:0]        index_mirror [MAX_SUBSET];
    logic [SET_SIZE_W-1:0]    n_mirror;
    logic [SUBSET_SIZE_W-1:0] k_mirror;

    rsp_t pending_subsets [$];

    int src_idle_pct;
    int sink_idle_pct;
    int mismatches;
    int commands_sent;
    int subsets_checked;
    int wraps_seen;
    int rejects_seen;
    int settings_applied;

    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_CMD, '{CMD_EMIT, 6'd0, 8'h00}, REG_SET_SIZE, 7'd0, 1'b1, RSP_AFTER_RESET},
        '{ROW_CMD, '{CMD_LOAD, 6'd0, 8'h00}, REG_SET_SIZE, 7'd0, 1'b0, RSP_NONE},
        '{ROW_CMD, '{CMD_LOAD, 6'd1, 8'hFF}, REG_SET_SIZE, 7'd0, 1'b0, RSP_NONE},
        '{ROW_CMD, '{CMD_RESTART, 6'd0, 8'h00}, REG_SET_SIZE, 7'd0, 1'b0, RSP_NONE},
        '{ROW_CMD, '{CMD_EMIT, 6'd63, 8'hFF}, REG_SET_SIZE, 7'd0, 1'b0, RSP_NONE},
        '{ROW_CMD, '{CMD_EMIT, 6'd0, 8'h00}, REG_SET_SIZE, 7'd0, 1'b0, RSP_NONE},
        '{ROW_CMD, '{CMD_UNUSED, 6'd63, 8'hFF}, REG_SET_SIZE, 7'd0, 1'b0, RSP_NONE},
        '{ROW_CFG, '{CMD_LOAD, 6'd0, 8'h00}, REG_SET_SIZE, 7'd1, 1'b0, RSP_NONE},
        '{ROW_CMD, '{CMD_EMIT, 6'd0, 8'h00}, REG_SET_SIZE, 7'd0, 1'b1, RSP_REJECTED},
        '{ROW_CFG, '{CMD_LOAD, 6'd0, 8'h00}, REG_SUBSET_SIZE, 7'd1, 1'b0, RSP_NONE},
        '{ROW_CMD, '{CMD_EMIT, 6'd0, 8'h00}, REG_SET_SIZE, 7'd0, 1'b1, RSP_SINGLE_FINAL},
        '{ROW_CMD, '{CMD_EMIT, 6'd0, 8'h00}, REG_SET_SIZE, 7'd0, 1'b1, RSP_SINGLE_FINAL},
        '{ROW_CFG, '{CMD_LOAD, 6'd0, 8'h00}, REG_SUBSET_SIZE, 7'd0, 1'b0, RSP_NONE},
        '{ROW_CMD, '{CMD_EMIT, 6'd0, 8'h00}, REG_SET_SIZE, 7'd0, 1'b1, RSP_REJECTED},
        '{ROW_CFG, '{CMD_LOAD, 6'd0, 8'h00}, REG_SUBSET_SIZE, 7'h7F, 1'b0, RSP_NONE},
        '{ROW_CMD, '{CMD_EMIT, 6'd0, 8'h00}, REG_SET_SIZE, 7'd0, 1'b1, RSP_REJECTED},
        '{ROW_CFG, '{CMD_LOAD, 6'd0, 8'h00}, REG_SET_SIZE, 7'd64, 1'b0, RSP_NONE},
        '{ROW_CFG, '{CMD_LOAD, 6'd0, 8'h00}, REG_SUBSET_SIZE, 7'd8, 1'b0, RSP_NONE},
        '{ROW_CMD, '{CMD_EMIT, 6'd0, 8'h00}, REG_SET_SIZE, 7'd0, 1'b0, RSP_NONE},
        '{ROW_CMD, '{CMD_LOAD, 6'd63, 8'h5A}, REG_SET_SIZE, 7'd0, 1'b0, RSP_NONE},
        '{ROW_CFG, '{CMD_LOAD, 6'd0, 8'h00}, REG_SET_SIZE, 7'd127, 1'b0, RSP_NONE},
        '{ROW_CMD, '{CMD_EMIT, 6'd0, 8'h00}, REG_SET_SIZE, 7'd0, 1'b1, RSP_REJECTED},
        '{ROW_CFG, '{CMD_LOAD, 6'd0, 8'h00}, REG_SET_SIZE, 7'd8, 1'b0, RSP_NONE},
        '{ROW_CMD, '{CMD_EMIT, 6'd0, 8'h00}, REG_SET_SIZE, 7'd0, 1'b0, RSP_NONE},
        '{ROW_CFG, '{CMD_LOAD, 6'd0, 8'h00}, REG_SET_SIZE, 7'd0, 1'b0, RSP_NONE},
        '{ROW_CMD, '{CMD_EMIT, 6'd0, 8'h00}, REG_SET_SIZE, 7'd0, 1'b1, RSP_REJECTED}
    };

    function automatic void rewind_indices();
        for (int i = 0; i < MAX_SUBSET; i++)
            index_mirror[i] = SLOT_W'(i);
    endfunction

    // Returns the subset at the current indices and steps to the next one.
    function automatic rsp_t next_subset();
        rsp_t              subset;
        logic [ITEM_W-1:0] picks [PICK_OUTPUTS];
        int                n;
        int                k;
        int                rise;
        subset = '0;
        n = int'(n_mirror);
        k = int'(k_mirror);
        for (int j = 0; j < PICK_OUTPUTS; j++)
            picks[j] = '0;
        if (k == 0 || k > MAX_SUBSET || n > MAX_SET || k > n)
        begin
            subset.bad_setting = 1'b1;
            return subset;
        end
        for (int j = 0; j < k; j++)
            picks[j] = item_mirror[index_mirror[j]];
        rise = -1;
        for (int j = 0; j < k; j++)
            if (int'(index_mirror[j]) < n - k + j)
                rise = j;
        if (rise < 0)
        begin
            subset.final_subset = 1'b1;
            rewind_indices();
        end
        else
        begin
            index_mirror[rise] = index_mirror[rise] + 1'b1;
            for (int i = rise + 1; i < k; i++)
                index_mirror[i] = index_mirror[i - 1] + 1'b1;
        end
        subset.pick_0 = picks[0];
        subset.pick_1 = picks[1];
        subset.pick_2 = picks[2];
        subset.pick_3 = picks[3];
        subset.pick_4 = picks[4];
        subset.pick_5 = picks[5];
        subset.pick_6 = picks[6];
        subset.pick_7 = picks[7];
        return subset;
    endfunction

    task automatic report_mismatch(input string what, input logic [71:0] got,
                                   input logic [71:0] want);
        $display("MISMATCH %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic check_subset(input rsp_t got);
        rsp_t want;
        if (pending_subsets.size() == 0)
        begin
            report_mismatch("subset with no command pending", got, 0);
            return;
        end
        want = pending_subsets.pop_front();
        subsets_checked++;
        if (want.final_subset)
            wraps_seen++;
        if (want.bad_setting)
            rejects_seen++;
        // pick_0 sits in the top byte of the packed result.
        for (int p = 0; p < PICK_OUTPUTS; p++)
            if (got[$bits(rsp_t)-1-8*p -: 8] !== want[$bits(rsp_t)-1-8*p -: 8])
                report_mismatch($sformatf("pick_%0d", p), got[$bits(rsp_t)-1-8*p -: 8],
                                want[$bits(rsp_t)-1-8*p -: 8]);
        if (got.final_subset !== want.final_subset)
            report_mismatch("final_subset", got.final_subset, want.final_subset);
        if (got.bad_setting !== want.bad_setting)
            report_mismatch("bad_setting", got.bad_setting, want.bad_setting);
    endtask

    task automatic send_command(input cmd_t item, input bit typed, input rsp_t typed_subset);
        rsp_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_chan.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_chan.valid   <= 1'b1;
        cmd_chan.payload <= item;
        @(posedge clk);
        while (!cmd_chan.ready)
            @(posedge clk);
        commands_sent++;
        case (item.command)
            CMD_LOAD:
                item_mirror[item.item_slot] = item.item_value;
            CMD_EMIT:
            begin
                predicted = next_subset();
                pending_subsets.insert(pending_subsets.size(),
                                       typed ? typed_subset : predicted);
            end
            CMD_RESTART:
                rewind_indices();
            default:
                ;
        endcase
    endtask

    // Stops sending, waits for every pending subset, then lets the block go quiet.
    task automatic settle(input int extra_cycles);
        cmd_chan.valid <= 1'b0;
        while (pending_subsets.size() != 0)
            @(posedge clk);
        repeat (extra_cycles)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index,
                                  input logic [CFG_DATA_W-1:0] reg_data);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= reg_data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (reg_index == REG_SET_SIZE)
            n_mirror = reg_data;
        else
            k_mirror = reg_data[SUBSET_SIZE_W-1:0];
        rewind_indices();
        settings_applied++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d subsets still pending", pending_subsets.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiving side: checks each transaction and stalls at random.
    initial
    begin
        subset_chan.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (subset_chan.valid && subset_chan.ready)
                check_subset(subset_chan.payload);
            subset_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        cmd_t              item;
        int                seg_len;
        int                roll;
        int                mode_items;
        bit                sweep;
        logic [6:0]        n_val;
        logic [3:0]        k_val;

        rst_n            <= 1'b0;
        cmd_chan.valid   <= 1'b0;
        cmd_chan.payload <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        mismatches       = 0;
        commands_sent    = 0;
        subsets_checked  = 0;
        wraps_seen       = 0;
        rejects_seen     = 0;
        settings_applied = 0;
        n_mirror         = SET_SIZE_RESET;
        k_mirror         = SUBSET_SIZE_RESET;
        rewind_indices();
        src_idle_pct  = 29;
        sink_idle_pct = 78;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every slot is written before any subset can read it.
        for (int s = 0; s < MAX_SET; s++)
            send_command('{CMD_LOAD, SLOT_W'(s), ITEM_W'(s * 4 + 3)}, 1'b0, RSP_NONE);

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_CFG)
            begin
                settle(SETTLE_CYCLES);
                write_register(plan[r].reg_index, plan[r].reg_data);
            end
            else
                send_command(plan[r].item, plan[r].typed, plan[r].subset);
        end

        for (int mode = 0; mode < 3; mode++)
        begin
            settle(SETTLE_CYCLES);
            case (mode)
                0:
                begin
                    src_idle_pct  = 29;
                    sink_idle_pct = 78;
                end
                1:
                begin
                    src_idle_pct  = 78;
                    sink_idle_pct = 29;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            mode_items = 0;
            for (int seg = 0; mode_items < RANDOM_ITEMS / 3; seg++)
            begin
                sweep = 1'b0;
                if (seg == 0)
                begin
                    // A full pass with one item per subset reaches the top slot and wraps.
                    n_val = 7'd64;
                    k_val = 4'd1;
                    sweep = 1'b1;
                end
                else if (seg == 1)
                begin
                    n_val = 7'd64;
                    k_val = 4'd8;
                end
                else if ($urandom_range(99) < 10)
                begin
                    case ($urandom_range(3))
                        0:
                        begin
                            k_val = 4'd0;
                            n_val = 7'($urandom_range(127));
                        end
                        1:
                        begin
                            k_val = 4'($urandom_range(9, 15));
                            n_val = 7'($urandom_range(127));
                        end
                        2:
                        begin
                            k_val = 4'($urandom_range(1, 8));
                            n_val = 7'($urandom_range(65, 127));
                        end
                        default:
                        begin
                            k_val = 4'($urandom_range(1, 8));
                            n_val = 7'($urandom_range(0, k_val - 1));
                        end
                    endcase
                end
                else
                begin
                    k_val = 4'($urandom_range(1, 8));
                    if ($urandom_range(3) != 0)
                        n_val = 7'(k_val + $urandom_range(0, 4));
                    else
                        n_val = 7'($urandom_range(k_val, 64));
                end

                settle(SETTLE_CYCLES);
                if ($urandom_range(1))
                begin
                    write_register(REG_SET_SIZE, n_val);
                    write_register(REG_SUBSET_SIZE, {3'($urandom), k_val});
                end
                else
                begin
                    write_register(REG_SUBSET_SIZE, {3'($urandom), k_val});
                    write_register(REG_SET_SIZE, n_val);
                end

                seg_len = sweep ? 70 : $urandom_range(30, 70);
                for (int i = 0; i < seg_len && mode_items < RANDOM_ITEMS / 3; i++)
                begin
                    if (seg == 1 && i == seg_len / 2)
                        settle(1);
                    roll = sweep ? 99 : $urandom_range(99);
                    item.item_slot  = SLOT_W'($urandom);
                    item.item_value = ITEM_W'($urandom);
                    if (roll < 3)
                        item.command = CMD_UNUSED;
                    else if (roll < 9)
                        item.command = CMD_RESTART;
                    else if (roll < 24)
                        item.command = CMD_LOAD;
                    else
                        item.command = CMD_EMIT;
                    send_command(item, 1'b0, RSP_NONE);
                    if (item.command != CMD_UNUSED)
                        mode_items++;
                end
            end
        end

        settle(SETTLE_CYCLES);
        $display("Run covered %0d commands and %0d checked subsets under %0d register writes.",
                 commands_sent, subsets_checked, settings_applied);
        $display("Subsets flagged final: %0d; emits rejected for unusable settings: %0d.",
                 wraps_seen, rejects_seen);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
